// File: rtl/assert_macros.svh
// assertion helper macros used by the core rtl file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HWD_ASSERT_IMPL(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("same-cycle implication check failed");

// next-cycle implication, checked outside reset
`define HWD_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("next-cycle implication check failed");

`endif

// File: rtl/hwd_pkg.sv
// types, codes and constants of the huffman tree-walk decoder
// no dependencies; used by every rtl module of the block but hwd_ram
package hwd_pkg;

  localparam int TREE_NODES_DEF = 512;
  localparam int SYMBOL_BITS    = 8;
  localparam int IDX_W          = 9;
  localparam int COUNT_W        = 32;
  localparam int CODE_BITS      = 8;
  localparam int BIT_CNT_W      = 3;
  localparam logic [BIT_CNT_W-1:0] TOP_BIT = 3'd7;
  localparam int QDEPTH         = 2;

  // operation codes of an input request
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_DECODE = 2'd2
  } hwd_op_t;

  // command kinds held in the queue
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_DECODE
  } hwd_cmd_kind_t;

  // walker states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } hwd_state_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [IDX_W-1:0]       node_index;
    logic                   node_is_leaf;
    logic [SYMBOL_BITS-1:0] node_symbol;
    logic [IDX_W-1:0]       left_child;
    logic [IDX_W-1:0]       right_child;
    logic [CODE_BITS-1:0]   code_byte;
  } hwd_in_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   last_of_byte;
    logic                   finished;
  } hwd_out_t;

  // one node table entry
  typedef struct packed {
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [IDX_W-1:0]       left;
    logic [IDX_W-1:0]       right;
  } hwd_node_t;

  localparam int NODE_W = $bits(hwd_node_t);

  // classified request passed from front to back
  typedef struct packed {
    hwd_cmd_kind_t        kind;
    logic [IDX_W-1:0]     index;
    hwd_node_t            node;
    logic [CODE_BITS-1:0] code;
  } hwd_cmd_t;

  // walker status seen by the top level
  typedef struct packed {
    logic walking;
    logic flushing;
    logic hold_valid;
    logic remaining_zero;
  } hwd_status_t;

endpackage

// File: rtl/hwd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module hwd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/hwd_front.sv
// front end: accepts requests, drops the meaningless ones, queues the rest
// depends on hwd_pkg
module hwd_front
  import hwd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hwd_in_t  in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output hwd_cmd_t q_cmd
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam logic [IDX_W:0] NODES_LIM = (IDX_W+1)'(TREE_NODES);

  hwd_cmd_t                 q_r [QDEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]           count_r, count_nxt;
  logic                     keep;
  hwd_cmd_t                 cmd;
  logic                     push;
  logic                     pop;

  // classify the request
  always_comb begin
    keep       = 1'b0;
    cmd.kind   = CMD_DECODE;
    cmd.index  = in_data.node_index;
    cmd.node   = '{leaf:   in_data.node_is_leaf,
                   symbol: in_data.node_symbol,
                   left:   in_data.left_child,
                   right:  in_data.right_child};
    cmd.code   = in_data.code_byte;
    unique case (in_data.operation)
      OP_LOAD: begin
        cmd.kind = CMD_LOAD;
        keep     = ({1'b0, in_data.node_index} < NODES_LIM);
      end
      OP_START: begin
        cmd.kind = CMD_START;
        keep     = 1'b1;
      end
      OP_DECODE: begin
        cmd.kind = CMD_DECODE;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // queue bookkeeping
  assign in_ready = (count_r != (PTR_W+1)'(QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// File: rtl/hwd_back.sv
// back end: loads the node table, walks the tree one code bit per cycle
// while the output is not stalled; depends on hwd_pkg and hwd_ram
module hwd_back
  import hwd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  hwd_cmd_t           q_cmd,
  input  logic [COUNT_W-1:0] symbol_count,
  output logic               out_valid,
  input  logic               out_ready,
  output hwd_out_t           out_data,
  output hwd_status_t        status
);

  localparam int ADDR_W = $clog2(TREE_NODES);
  localparam logic [IDX_W:0] NODES_LIM = (IDX_W+1)'(TREE_NODES);

  hwd_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic                   beyond_r, beyond_nxt;
  logic [COUNT_W-1:0]     remaining_r, remaining_nxt;
  logic                   hold_valid_r, hold_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  hwd_out_t               out_data_r, out_data_nxt;
  logic [SYMBOL_BITS-1:0] hold_sym_r, hold_sym_nxt;
  logic                   hold_fin_r, hold_fin_nxt;
  logic [CODE_BITS-1:0]   byte_r, byte_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  hwd_node_t              root_r, root_nxt;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [NODE_W-1:0]      ram_rdata;

  hwd_node_t              e_cur;
  hwd_node_t              e_nav;
  logic                   leaf;
  logic [COUNT_W-1:0]     rem_dec;
  logic                   fin;
  logic                   code_bit;
  logic [IDX_W-1:0]       next_node;
  logic                   last_bit;
  logic                   need_push;
  logic                   out_can;

  // node table
  hwd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TREE_NODES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_cmd.node),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one bit step of the walk
  assign e_cur     = beyond_r ? '0 : hwd_node_t'(ram_rdata);
  assign leaf      = e_cur.leaf;
  assign rem_dec   = remaining_r - COUNT_W'(1);
  assign fin       = leaf && (rem_dec == '0);
  assign e_nav     = leaf ? root_r : e_cur;
  assign code_bit  = byte_r[bit_cnt_r];
  assign next_node = code_bit ? e_nav.right : e_nav.left;
  assign last_bit  = (bit_cnt_r == '0);
  assign need_push = hold_valid_r && (leaf || last_bit);
  assign out_can   = !out_valid_r || out_ready;

  // walker sequencing
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    beyond_nxt     = beyond_r;
    remaining_nxt  = remaining_r;
    hold_valid_nxt = hold_valid_r;
    hold_sym_nxt   = hold_sym_r;
    hold_fin_nxt   = hold_fin_r;
    byte_nxt       = byte_r;
    bit_cnt_nxt    = bit_cnt_r;
    root_nxt       = root_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = q_cmd.index[ADDR_W-1:0];
    ram_re         = 1'b0;
    ram_raddr      = cur_r[ADDR_W-1:0];
    q_ready        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_LOAD: begin
              ram_we = 1'b1;
              if (q_cmd.index == '0) begin
                root_nxt = q_cmd.node;
              end
            end
            CMD_START: begin
              remaining_nxt = symbol_count;
              cur_nxt       = '0;
              beyond_nxt    = 1'b0;
            end
            CMD_DECODE: begin
              if (remaining_r != '0) begin
                byte_nxt    = q_cmd.code;
                bit_cnt_nxt = TOP_BIT;
                ram_re      = 1'b1;
                state_nxt   = ST_WALK;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!need_push || out_can) begin
          // earlier symbol goes out once it is known whether it ends the byte
          if (need_push) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{symbol: hold_sym_r, last_of_byte: !leaf,
                              finished: hold_fin_r};
          end
          if (leaf) begin
            hold_valid_nxt = 1'b1;
            hold_sym_nxt   = e_cur.symbol;
            hold_fin_nxt   = fin;
            remaining_nxt  = rem_dec;
          end else if (last_bit) begin
            hold_valid_nxt = 1'b0;
          end
          if (fin) begin
            cur_nxt    = '0;
            beyond_nxt = 1'b0;
            state_nxt  = ST_FLUSH;
          end else begin
            cur_nxt    = next_node;
            beyond_nxt = !({1'b0, next_node} < NODES_LIM);
            ram_re     = 1'b1;
            ram_raddr  = next_node[ADDR_W-1:0];
            if (last_bit) begin
              state_nxt = leaf ? ST_FLUSH : ST_IDLE;
            end else begin
              bit_cnt_nxt = bit_cnt_r - 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        // last symbol of the byte
        if (out_can) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '{symbol: hold_sym_r, last_of_byte: 1'b1,
                             finished: hold_fin_r};
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_r        <= '0;
      beyond_r     <= 1'b0;
      remaining_r  <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      beyond_r     <= beyond_nxt;
      remaining_r  <= remaining_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_sym_r <= hold_sym_nxt;
    hold_fin_r <= hold_fin_nxt;
    byte_r     <= byte_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    root_r     <= root_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status = '{walking:        (state_r == ST_WALK),
                    flushing:       (state_r == ST_FLUSH),
                    hold_valid:     hold_valid_r,
                    remaining_zero: (remaining_r == '0)};

endmodule

// File: rtl/huffman_tree_walk_decoder_core.sv
// decode request: popped from the queue by the walker in its idle state, which also reads the
// current node; then one walk step per code bit (8), plus a flush step when the byte ends on a
// symbol; the walk ends early when the count runs out, and output stalls hold the walk.
// the walker takes no new code byte until it is back at rest, as each bit step uses the node
// read by the step before; load and start requests are handled in the idle state.
// reset clears the queue, walker, counter and symbol_count; table is undefined until loaded.
`include "assert_macros.svh"

module huffman_tree_walk_decoder_core
  import hwd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hwd_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hwd_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic               q_valid;
  logic               q_ready;
  hwd_cmd_t           q_cmd;
  logic [COUNT_W-1:0] symbol_count_r;
  hwd_status_t        status;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      symbol_count_r <= cfg_data;
    end
  end

  hwd_front #(
    .TREE_NODES (TREE_NODES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  hwd_back #(
    .TREE_NODES (TREE_NODES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd),
    .symbol_count (symbol_count_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .status       (status)
  );

  // walking only happens with symbols left to decode
  `HWD_ASSERT_IMPL(a_walk_has_count, clk, rst_n, status.walking, !status.remaining_zero)
  // flush state always has a held symbol to send
  `HWD_ASSERT_IMPL(a_flush_has_hold, clk, rst_n, status.flushing, status.hold_valid)
  // the symbol that finishes the stream closes its byte
  `HWD_ASSERT_IMPL(a_fin_is_last, clk, rst_n, out_valid && out_data.finished,
                   out_data.last_of_byte)
  // after a finishing symbol is produced the walker has left the walk state
  `HWD_ASSERT_NEXT(a_fin_stops_walk, clk, rst_n,
                   status.walking && status.hold_valid && status.remaining_zero,
                   !status.walking)

endmodule

// File: tb/huffman_tree_walk_decoder_core_tb.sv
// self-checking testbench for the huffman tree-walk decoder core
// depends on hwd_pkg and huffman_tree_walk_decoder_core; checks every decoded symbol
// against a tree walker kept in step with the accepted requests
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_core_tb;
  import hwd_pkg::*;

  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         SEG_ITEMS    = 34;
  localparam int         NUM_SEGS     = 9;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hwd_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hwd_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  // requests waiting for the driver, symbols waiting for the block
  hwd_in_t  queued_requests[$];
  hwd_out_t pending_symbols[$];
  hwd_out_t want_sym;

  // walker state mirrored from accepted requests
  hwd_node_t          tree_mem [0:511];
  logic [IDX_W-1:0]   walk_at = '0;
  logic [COUNT_W-1:0] syms_left = '0;
  logic [COUNT_W-1:0] cfg_count = '0;

  // table entries that are safe to walk into
  bit node_written [0:511];
  int written_list[$];

  int send_idle = 37;
  int recv_idle = 53;
  int queued_items = 0;
  int mismatches = 0;

  huffman_tree_walk_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // apply one accepted request to the mirrored walker, queue the symbols it yields
  task automatic apply_request(hwd_in_t req);
    hwd_node_t cur;
    hwd_out_t  res;
    int        n_emit;
    n_emit = 0;
    case (req.operation)
      OP_LOAD: begin
        tree_mem[req.node_index] = '{req.node_is_leaf, req.node_symbol,
                                     req.left_child, req.right_child};
      end
      OP_START: begin
        syms_left = cfg_count;
        walk_at   = '0;
      end
      OP_DECODE: begin
        if (syms_left != 0) begin
          for (int b = CODE_BITS - 1; b >= 0; b--) begin
            cur = tree_mem[walk_at];
            // leaf reached: emit, go back to the root before using this bit
            if (cur.leaf) begin
              syms_left--;
              res.symbol       = cur.symbol;
              res.last_of_byte = 1'b0;
              res.finished     = (syms_left == 0);
              pending_symbols.push_back(res);
              n_emit++;
              walk_at = '0;
              cur     = tree_mem[0];
            end
            if (syms_left == 0) break;
            walk_at = req.code_byte[b] ? cur.right : cur.left;
          end
          if (n_emit > 0) pending_symbols[$].last_of_byte = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // driver: one request in flight, random gaps between requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request(in_data);
      if (!in_valid || in_ready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_data  <= queued_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted symbol with the oldest pending one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_symbols.size() == 0) begin
          report_mismatch("symbol with none pending", 32'(out_data.symbol), 32'd0);
        end else begin
          want_sym = pending_symbols.pop_front();
          if (out_data.symbol !== want_sym.symbol)
            report_mismatch("symbol", 32'(out_data.symbol), 32'(want_sym.symbol));
          if (out_data.last_of_byte !== want_sym.last_of_byte)
            report_mismatch("last_of_byte", 32'(out_data.last_of_byte),
                            32'(want_sym.last_of_byte));
          if (out_data.finished !== want_sym.finished)
            report_mismatch("finished", 32'(out_data.finished), 32'(want_sym.finished));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic hwd_in_t noise_fields();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[$bits(hwd_in_t)-1:0];
  endfunction

  task automatic mark_written(int idx);
    if (!node_written[idx]) begin
      node_written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  task automatic push_load(int idx, bit leaf, int sym, int lft, int rgt);
    hwd_in_t r;
    r = noise_fields();
    r.operation    = OP_LOAD;
    r.node_index   = IDX_W'(idx);
    r.node_is_leaf = leaf;
    r.node_symbol  = SYMBOL_BITS'(sym);
    r.left_child   = IDX_W'(lft);
    r.right_child  = IDX_W'(rgt);
    queued_requests.push_back(r);
    queued_items++;
  endtask

  // start, decode or unknown request; other fields stay random
  task automatic push_op(logic [1:0] op, logic [7:0] code);
    hwd_in_t r;
    r = noise_fields();
    r.operation = op;
    r.code_byte = code;
    queued_requests.push_back(r);
    if (op != OP_UNKNOWN) queued_items++;
  endtask

  // random code tree rooted at entry 0, loaded as one block of requests
  task automatic push_tree(int leaves);
    bit taken [0:511];
    bit inner [0:511];
    int lft [0:511];
    int rgt [0:511];
    int open_leaves[$];
    int members[$];
    int k, p, a, b;
    taken[0] = 1'b1;
    open_leaves.push_back(0);
    members.push_back(0);
    for (int s = 1; s < leaves; s++) begin
      // often split the newest leaf so some codes run deeper than a byte
      k = ($urandom_range(2) == 0) ? open_leaves.size() - 1
                                   : $urandom_range(open_leaves.size() - 1);
      p = open_leaves[k];
      open_leaves.delete(k);
      do a = $urandom_range(511, 1); while (taken[a]);
      taken[a] = 1'b1;
      do b = $urandom_range(511, 1); while (taken[b]);
      taken[b] = 1'b1;
      inner[p] = 1'b1;
      lft[p] = a;
      rgt[p] = b;
      open_leaves.push_back(a);
      open_leaves.push_back(b);
      members.push_back(a);
      members.push_back(b);
    end
    foreach (members[m]) begin
      p = members[m];
      if (inner[p])
        push_load(p, 1'b0, $urandom_range(255), lft[p], rgt[p]);
      else if (p == 0)
        // a leaf at the root walks through its own child fields
        push_load(0, 1'b1, $urandom_range(255), pick_written(), pick_written());
      else
        push_load(p, 1'b1, $urandom_range(255), $urandom_range(511), $urandom_range(511));
    end
    foreach (members[m]) mark_written(members[m]);
  endtask

  // stray request that keeps every walkable entry pointing at written ones
  task automatic push_noise();
    int idx;
    bit leaf;
    case ($urandom_range(3))
      0: push_op(OP_UNKNOWN, CODE_BITS'($urandom_range(255)));
      1: begin
        idx  = $urandom_range(511);
        leaf = 1'($urandom_range(1));
        if (leaf && idx != 0)
          push_load(idx, 1'b1, $urandom_range(255), $urandom_range(511), $urandom_range(511));
        else
          push_load(idx, leaf, $urandom_range(255), pick_written(), pick_written());
        mark_written(idx);
      end
      2: push_op(OP_START, CODE_BITS'($urandom_range(255)));
      default: push_op(OP_DECODE, CODE_BITS'($urandom_range(255)));
    endcase
  endtask

  // new tree, start, then a run of code bytes
  task automatic push_session();
    int n;
    push_tree(($urandom_range(7) == 0) ? 1 : $urandom_range(16, 2));
    push_op(OP_START, CODE_BITS'($urandom_range(255)));
    n = $urandom_range(12, 3);
    repeat (n) begin
      if ($urandom_range(9) == 0) push_noise();
      else push_op(OP_DECODE, CODE_BITS'($urandom_range(255)));
    end
  endtask

  // wait for the block to go quiet, including requests that yield nothing
  task automatic settle();
    while (queued_requests.size() != 0 || in_valid || pending_symbols.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_count = v;
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [COUNT_W-1:0] seg_count;
    int target;
    foreach (tree_mem[i]) tree_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero count after reset: nothing decodes, unknown op ignored
    push_op(OP_UNKNOWN, 8'hFF);
    push_op(OP_DECODE, 8'hFF);
    push_load(0, 1'b1, 8'hFF, 0, 0);
    mark_written(0);
    push_op(OP_START, 8'h00);
    push_op(OP_DECODE, 8'h00);

    // leaf at the root, count runs out in the middle of a byte
    write_count(32'd5);
    push_op(OP_START, 8'h00);
    push_op(OP_DECODE, 8'h00);
    push_op(OP_DECODE, 8'h3C);

    // two-leaf tree at the ends of the table, count never runs out
    write_count(32'hFFFF_FFFF);
    push_load(511, 1'b1, 8'h00, 511, 0);
    push_load(1, 1'b1, 8'hA5, 0, 511);
    push_load(0, 1'b0, 8'h5A, 1, 511);
    mark_written(1);
    mark_written(511);
    push_op(OP_START, 8'hFF);
    push_op(OP_DECODE, 8'h00);
    push_op(OP_DECODE, 8'hFF);
    push_op(OP_DECODE, 8'hA5);
    push_op(OP_DECODE, 8'h5A);
    push_op(OP_UNKNOWN, 8'h00);

    // random sessions, count and idling changed per segment
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        1: seg_count = 32'hFFFF_FFFF;
        2: seg_count = 32'd0;
        3: seg_count = 32'd1;
        4: seg_count = $urandom;
        default: seg_count = $urandom_range(60, 2);
      endcase
      write_count(seg_count);
      send_idle = (seg < 3) ? 37 : (seg < 6) ? 53 : 0;
      recv_idle = (seg < 3) ? 53 : (seg < 6) ? 37 : 0;
      target = queued_items + SEG_ITEMS;
      while (queued_items < target) push_session();
    end

    while (queued_requests.size() != 0 || in_valid || pending_symbols.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("huffman_tree_walk_decoder_core: match");
    end else begin
      $display("huffman_tree_walk_decoder_core: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("huffman_tree_walk_decoder_core: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/hwd_pkg.sv
rtl/hwd_ram.sv
rtl/hwd_front.sv
rtl/hwd_back.sv
rtl/huffman_tree_walk_decoder_core.sv
tb/huffman_tree_walk_decoder_core_tb.sv
